// ----- rtl/budgeted_buffer_slot_pool_assert.svh -----
// ----------------------------------------------------------------------------
// Slot pool assertion macros
// Shared property forms for the slot pool checker.
// ----------------------------------------------------------------------------
`ifndef BUDGETED_BUFFER_SLOT_POOL_ASSERT_SVH
`define BUDGETED_BUFFER_SLOT_POOL_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define BBSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool package
// Types, codes and constants shared by the slot pool modules.
// ----------------------------------------------------------------------------
package bbsp_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int PAGE_SHIFT    = 12;
   localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;
   localparam int BYTES_W       = 32;
   localparam int PAGES_W       = BYTES_W + 1 - PAGE_SHIFT;
   localparam int BUDGET_W      = 25;
   localparam int SUM_W         = BUDGET_W + 1;
   localparam int SLOT_W        = 8;
   localparam int FREE_W        = 5;

   localparam logic [SLOT_W-1:0]   NO_SLOT      = 8'hFF;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 25'd16777216;

   typedef enum logic [2:0] {
      ACT_ACQUIRE,
      ACT_RELEASE,
      ACT_CANCEL,
      ACT_COMPLETE,
      ACT_BEGIN_DECODE,
      ACT_RESTORE_DECODE,
      ACT_REMAP,
      ACT_UNUSED
   } action_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NO_SLOT,
      ST_ALREADY_FREE,
      ST_WRONG_PHASE,
      ST_BAD_ID
   } status_type;

   typedef enum logic [2:0] {
      PH_FREE,
      PH_READ,
      PH_CANCEL_PENDING,
      PH_DATA_AVAIL,
      PH_DECODE
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PICK,
      S_PICKED,
      S_TRIM_CHECK,
      S_TRIM_SCAN,
      S_TRIM_END,
      S_COMMIT,
      S_DROP,
      S_DONE
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  slot_id;
      logic [31:0] byte_count;
      logic [31:0] image_tag;
      logic [63:0] generation_tag;
   } req_type;

   typedef struct packed {
      logic [7:0]  granted_slot;
      status_type  status;
      logic [24:0] committed_total;
      logic [4:0]  free_slots;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       op_apply;
      logic       pick_step;
      logic       trim_init;
      logic       trim_step;
      logic       trim_apply;
      logic       commit;
      logic       drop_step;
      logic       finish;
      logic       grant;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic       is_acquire;
      logic       acq_reject;
      logic       scan_last;
      logic       best_enough;
      logic       over_budget;
      logic       victim_found;
      status_type op_status;
   } stat_type;

endpackage

// ----- rtl/bbsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot pool controller
// Sequences request decode, best-fit scan, trimming, commit and list compaction.
// ----------------------------------------------------------------------------
module bbsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bbsp_pkg::stat_type stat,
   output bbsp_pkg::cmd_type  cmd
);

   bbsp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbsp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = bbsp_pkg::ST_OK;
      case (state_ff)
         bbsp_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = bbsp_pkg::S_CHECK;
            end
         end
         bbsp_pkg::S_CHECK: begin
            if (!stat.is_acquire) begin
               cmd.op_apply = 1'b1;
               cmd.finish   = 1'b1;
               cmd.status   = stat.op_status;
               state_in     = bbsp_pkg::S_IDLE;
            end else if (stat.acq_reject) begin
               cmd.finish = 1'b1;
               cmd.status = bbsp_pkg::ST_NO_SLOT;
               state_in   = bbsp_pkg::S_IDLE;
            end else begin
               state_in = bbsp_pkg::S_PICK;
            end
         end
         bbsp_pkg::S_PICK: begin
            cmd.pick_step = 1'b1;
            if (stat.scan_last) begin
               state_in = bbsp_pkg::S_PICKED;
            end
         end
         bbsp_pkg::S_PICKED: begin
            state_in = stat.best_enough ? bbsp_pkg::S_COMMIT : bbsp_pkg::S_TRIM_CHECK;
         end
         bbsp_pkg::S_TRIM_CHECK: begin
            if (stat.over_budget) begin
               cmd.trim_init = 1'b1;
               state_in      = bbsp_pkg::S_TRIM_SCAN;
            end else begin
               state_in = bbsp_pkg::S_COMMIT;
            end
         end
         bbsp_pkg::S_TRIM_SCAN: begin
            cmd.trim_step = 1'b1;
            if (stat.scan_last) begin
               state_in = bbsp_pkg::S_TRIM_END;
            end
         end
         bbsp_pkg::S_TRIM_END: begin
            if (stat.victim_found) begin
               cmd.trim_apply = 1'b1;
               state_in       = bbsp_pkg::S_TRIM_CHECK;
            end else begin
               cmd.finish = 1'b1;
               cmd.status = bbsp_pkg::ST_NO_SLOT;
               state_in   = bbsp_pkg::S_IDLE;
            end
         end
         bbsp_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = bbsp_pkg::S_DROP;
         end
         bbsp_pkg::S_DROP: begin
            cmd.drop_step = 1'b1;
            if (stat.scan_last) begin
               state_in = bbsp_pkg::S_DONE;
            end
         end
         bbsp_pkg::S_DONE: begin
            cmd.finish = 1'b1;
            cmd.grant  = 1'b1;
            state_in   = bbsp_pkg::S_IDLE;
         end
         default: begin
            state_in = bbsp_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bbsp_pkg::S_IDLE);

endmodule

// ----- rtl/bbsp_datapath.sv -----
// ----------------------------------------------------------------------------
// Slot pool datapath
// Slot tables, free order, page accounting and the registered result.
// ----------------------------------------------------------------------------
module bbsp_datapath #(
   parameter int SLOTS = bbsp_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bbsp_pkg::cmd_type              cmd,
   output bbsp_pkg::stat_type             stat,
   input  bbsp_pkg::req_type              req_item,
   input  logic                           csr_valid,
   input  logic [bbsp_pkg::BUDGET_W-1:0]  csr_data,
   output logic                           rsp_strobe,
   output bbsp_pkg::rsp_type              rsp_item
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int PW    = bbsp_pkg::PAGES_W;
   localparam int BW    = bbsp_pkg::BUDGET_W;
   localparam int SW    = bbsp_pkg::SUM_W;

   // slot tables
   logic [PW-1:0]       pages_ff [SLOTS];
   bbsp_pkg::phase_type phase_ff [SLOTS];
   logic [IDX_W-1:0]    order_ff [SLOTS];
   logic [31:0]         image_mem [SLOTS];
   logic [63:0]         gen_mem [SLOTS];

   logic [BW-1:0]    budget_ff, committed_ff, committed_in;
   logic [CNT_W-1:0] free_len_ff, free_len_in;
   logic [CNT_W-1:0] idx_ff, idx_in, j_ff, j_in;

   // latched request
   bbsp_pkg::action_type act_ff;
   logic [7:0]           id_ff;
   logic [PW-1:0]        need_ff;
   logic                 zero_ff;
   logic [31:0]          image_ff;
   logic [63:0]          gen_ff;

   // scan registers
   logic [IDX_W-1:0] best_ff, best_in, vic_ff, vic_in;
   logic [PW-1:0]    bp_ff, bp_in, vp_ff, vp_in;
   logic             fits_ff, fits_in, vfound_ff, vfound_in;

   bbsp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_strobe_ff;

   // write ports
   logic                pages_we, phase_we, order_we, image_we, gen_we;
   logic [IDX_W-1:0]    pages_wa, phase_wa, order_wa, tag_wa;
   logic [PW-1:0]       pages_wd;
   bbsp_pkg::phase_type phase_wd;
   logic [IDX_W-1:0]    order_wd;
   logic [31:0]         image_wd;
   logic [63:0]         gen_wd;

   logic [bbsp_pkg::BYTES_W:0] round_sum;
   logic [IDX_W-1:0]           scan_s, id_ix;
   logic [PW-1:0]              scan_cap, after_pages;
   logic                       id_ok, op_ok;
   bbsp_pkg::phase_type        cur_phase;
   bbsp_pkg::status_type       op_status;

   assign round_sum = {1'b0, req_item.byte_count} + (bbsp_pkg::BYTES_W + 1)'(bbsp_pkg::PAGE_BYTES - 1);
   assign scan_s    = order_ff[idx_ff[IDX_W-1:0]];
   assign scan_cap  = pages_ff[scan_s];
   assign id_ok     = (id_ff < 8'(SLOTS));
   assign id_ix     = id_ff[IDX_W-1:0];
   assign cur_phase = phase_ff[id_ix];
   assign after_pages = (bp_ff < need_ff) ? need_ff : bp_ff;

   // status of a non-acquire action
   always_comb begin
      op_status = bbsp_pkg::ST_OK;
      case (act_ff)
         bbsp_pkg::ACT_RELEASE,
         bbsp_pkg::ACT_CANCEL,
         bbsp_pkg::ACT_COMPLETE,
         bbsp_pkg::ACT_BEGIN_DECODE,
         bbsp_pkg::ACT_RESTORE_DECODE,
         bbsp_pkg::ACT_REMAP: begin
            if (act_ff == bbsp_pkg::ACT_RELEASE && id_ff == bbsp_pkg::NO_SLOT) begin
               op_status = bbsp_pkg::ST_OK;
            end else if (!id_ok) begin
               op_status = bbsp_pkg::ST_BAD_ID;
            end else begin
               case (act_ff)
                  bbsp_pkg::ACT_RELEASE: begin
                     if (cur_phase == bbsp_pkg::PH_FREE) op_status = bbsp_pkg::ST_ALREADY_FREE;
                  end
                  bbsp_pkg::ACT_CANCEL: begin
                     if (cur_phase != bbsp_pkg::PH_READ &&
                         cur_phase != bbsp_pkg::PH_CANCEL_PENDING) begin
                        op_status = bbsp_pkg::ST_WRONG_PHASE;
                     end
                  end
                  bbsp_pkg::ACT_COMPLETE: begin
                     if (cur_phase != bbsp_pkg::PH_READ) op_status = bbsp_pkg::ST_WRONG_PHASE;
                  end
                  bbsp_pkg::ACT_BEGIN_DECODE: begin
                     if (cur_phase != bbsp_pkg::PH_DATA_AVAIL) begin
                        op_status = bbsp_pkg::ST_WRONG_PHASE;
                     end
                  end
                  bbsp_pkg::ACT_RESTORE_DECODE: begin
                     if (cur_phase != bbsp_pkg::PH_DECODE) op_status = bbsp_pkg::ST_WRONG_PHASE;
                  end
                  default: begin
                     if (cur_phase == bbsp_pkg::PH_FREE) op_status = bbsp_pkg::ST_WRONG_PHASE;
                  end
               endcase
            end
         end
         default: begin
            op_status = bbsp_pkg::ST_OK;
         end
      endcase
   end

   assign op_ok = (op_status == bbsp_pkg::ST_OK) && id_ok &&
                  (act_ff != bbsp_pkg::ACT_ACQUIRE) && (act_ff != bbsp_pkg::ACT_UNUSED);

   // status to the controller
   always_comb begin
      stat.is_acquire   = (act_ff == bbsp_pkg::ACT_ACQUIRE);
      stat.acq_reject   = zero_ff || (BW'(need_ff) > budget_ff) || (free_len_ff == '0);
      stat.scan_last    = ((idx_ff + CNT_W'(1)) == free_len_ff);
      stat.best_enough  = (bp_ff >= need_ff);
      stat.over_budget  = (SW'(committed_ff) + SW'(need_ff)) > (SW'(budget_ff) + SW'(bp_ff));
      stat.victim_found = vfound_ff;
      stat.op_status    = op_status;
   end

   // next values and write ports
   always_comb begin
      committed_in = committed_ff;
      free_len_in  = free_len_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      bp_in        = bp_ff;
      fits_in      = fits_ff;
      vic_in       = vic_ff;
      vp_in        = vp_ff;
      vfound_in    = vfound_ff;
      pages_we = 1'b0; pages_wa = best_ff; pages_wd = after_pages;
      phase_we = 1'b0; phase_wa = id_ix;   phase_wd = bbsp_pkg::PH_READ;
      order_we = 1'b0; order_wa = j_ff[IDX_W-1:0]; order_wd = scan_s;
      image_we = 1'b0; gen_we   = 1'b0;    tag_wa   = id_ix;
      image_wd = image_ff; gen_wd = gen_ff;

      if (cmd.load) begin
         idx_in = '0;
      end
      if (cmd.op_apply && op_ok) begin
         phase_we = 1'b1;
         case (act_ff)
            bbsp_pkg::ACT_RELEASE: begin
               phase_wd = bbsp_pkg::PH_FREE;
               image_we = 1'b1;
               gen_we   = 1'b1;
               image_wd = '0;
               gen_wd   = '0;
               if (free_len_ff < CNT_W'(SLOTS)) begin
                  order_we    = 1'b1;
                  order_wa    = free_len_ff[IDX_W-1:0];
                  order_wd    = id_ix;
                  free_len_in = free_len_ff + CNT_W'(1);
               end
            end
            bbsp_pkg::ACT_CANCEL:         phase_wd = bbsp_pkg::PH_CANCEL_PENDING;
            bbsp_pkg::ACT_COMPLETE:       phase_wd = bbsp_pkg::PH_DATA_AVAIL;
            bbsp_pkg::ACT_BEGIN_DECODE:   phase_wd = bbsp_pkg::PH_DECODE;
            bbsp_pkg::ACT_RESTORE_DECODE: phase_wd = bbsp_pkg::PH_DATA_AVAIL;
            default: begin
               // remap: keep the phase and the generation, rebind the image
               phase_wd = cur_phase;
               image_we = 1'b1;
            end
         endcase
      end
      if (cmd.pick_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (idx_ff == '0) begin
            best_in = scan_s; bp_in = scan_cap; fits_in = (scan_cap >= need_ff);
         end else if (scan_cap >= need_ff && (!fits_ff || scan_cap < bp_ff)) begin
            best_in = scan_s; bp_in = scan_cap; fits_in = 1'b1;
         end else if (!fits_ff && scan_cap > bp_ff) begin
            best_in = scan_s; bp_in = scan_cap;
         end
      end
      if (cmd.trim_init) begin
         idx_in    = '0;
         vfound_in = 1'b0;
      end
      if (cmd.trim_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (scan_s != best_ff && scan_cap != '0 && (!vfound_ff || scan_cap > vp_ff)) begin
            vic_in = scan_s; vp_in = scan_cap; vfound_in = 1'b1;
         end
      end
      if (cmd.trim_apply) begin
         committed_in = committed_ff - BW'(vp_ff);
         pages_we = 1'b1; pages_wa = vic_ff; pages_wd = '0;
      end
      if (cmd.commit) begin
         committed_in = committed_ff - BW'(bp_ff) + BW'(after_pages);
         pages_we = 1'b1;
         phase_we = 1'b1; phase_wa = best_ff; phase_wd = bbsp_pkg::PH_READ;
         image_we = 1'b1; gen_we   = 1'b1;    tag_wa   = best_ff;
         idx_in   = '0;
         j_in     = '0;
      end
      if (cmd.drop_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (scan_s != best_ff) begin
            order_we = 1'b1;
            j_in     = j_ff + CNT_W'(1);
         end
         if (stat.scan_last) begin
            free_len_in = j_in;
         end
      end

      rsp_in.granted_slot    = cmd.grant ? 8'(best_ff) : bbsp_pkg::NO_SLOT;
      rsp_in.status          = cmd.status;
      rsp_in.committed_total = committed_in;
      rsp_in.free_slots      = bbsp_pkg::FREE_W'(free_len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff     <= bbsp_pkg::BUDGET_RESET;
         committed_ff  <= '0;
         free_len_ff   <= CNT_W'(SLOTS);
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            pages_ff[i] <= '0;
            phase_ff[i] <= bbsp_pkg::PH_FREE;
            order_ff[i] <= IDX_W'(i);
         end
      end else begin
         if (csr_valid) budget_ff <= csr_data;
         committed_ff  <= committed_in;
         free_len_ff   <= free_len_in;
         rsp_strobe_ff <= cmd.finish;
         if (pages_we) pages_ff[pages_wa] <= pages_wd;
         if (phase_we) phase_ff[phase_wa] <= phase_wd;
         if (order_we) order_ff[order_wa] <= order_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (image_we) image_mem[tag_wa] <= image_wd;
      if (gen_we)   gen_mem[tag_wa]   <= gen_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_item.action;
         id_ff    <= req_item.slot_id;
         need_ff  <= PW'(round_sum >> bbsp_pkg::PAGE_SHIFT);
         zero_ff  <= (req_item.byte_count == '0);
         image_ff <= req_item.image_tag;
         gen_ff   <= req_item.generation_tag;
      end
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      best_ff   <= best_in;
      bp_ff     <= bp_in;
      fits_ff   <= fits_in;
      vic_ff    <= vic_in;
      vp_ff     <= vp_in;
      vfound_ff <= vfound_in;
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- rtl/budgeted_buffer_slot_pool.sv -----
// ----------------------------------------------------------------------------
// Budgeted buffer slot pool
// Pool of buffer slots under a page budget: acquire, release, phase control.
// ----------------------------------------------------------------------------
// Raise start with a request on req_item while busy is low; the beat is taken
// on that edge and busy stays high until the result is out. Exactly one result
// beat follows each request, on rsp_item for one cycle with rsp_strobe high;
// there is no back-pressure, so the receiver must take it in that cycle. busy
// falls in the strobe cycle, so the next request may be given alongside it.
// Non-acquire actions hold busy for the CHECK state only, as does an acquire
// turned away at once. An acquire walks the free list one entry per cycle:
// the best-fit scan, then, when the chosen slot must grow, one victim scan
// per trimmed slot, then the list compaction scan. A growth that trimming
// cannot cover ends after a victim scan that finds no victim, with no commit.
// The budget register is written through csr_valid/csr_data; the user must
// write it only while the pool is idle, as the block itself does not enforce
// this. csr_ready is always high.
module budgeted_buffer_slot_pool #(
   parameter int SLOTS = bbsp_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  bbsp_pkg::req_type             req_item,
   // result channel
   output logic                          rsp_strobe,
   output bbsp_pkg::rsp_type             rsp_item,
   // budget register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbsp_pkg::BUDGET_W-1:0] csr_data
);

   bbsp_pkg::cmd_type  cmd;
   bbsp_pkg::stat_type stat;

   // sequencer: one step of the scan or update per cycle
   bbsp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // slot tables, accounting and result register
   bbsp_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // budget writes are always taken
   assign csr_ready = 1'b1;

endmodule

// ----- rtl/bbsp_checker.sv -----
// ----------------------------------------------------------------------------
// Slot pool checker
// Port-level checks of the request/result sequencing.
// ----------------------------------------------------------------------------
`include "budgeted_buffer_slot_pool_assert.svh"

module bbsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input bbsp_pkg::rsp_type rsp_item
);

   `BBSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy did not rise after accept")
   `BBSP_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result beat while still busy")
   `BBSP_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result beats back to back")
   `BBSP_ASSERT_NOW(a_grant_ok, clock, reset, rsp_strobe && (rsp_item.granted_slot != bbsp_pkg::NO_SLOT), rsp_item.status == bbsp_pkg::ST_OK, "grant with bad status")

endmodule

bind budgeted_buffer_slot_pool bbsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
